@@ design/prq_pkg.sv @@
package prq_pkg;

   // Operation codes carried on the request side
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   // Result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

   // Engine sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_WR,
      ST_RM_RD,
      ST_RM_CHK,
      ST_HEAD_RD,
      ST_HEAD_WAIT
   } state_type;

   // One queue slot as stored in memory
   typedef struct packed {
      logic [7:0] prio;
      logic [7:0] task_id;
   } slot_type;

   // Engine handshake status toward the top level
   typedef struct packed {
      logic idle;
      logic done;
   } eng_status_type;

   // Outcome of one item, held until the top level takes it
   typedef struct packed {
      logic [1:0] status;
      logic       head_valid;
      logic [7:0] head_id;
      logic [5:0] count;
   } eng_result_type;

endpackage

@@ design/prq_engine.sv @@
module prq_engine #(
   parameter int MAX_TASKS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    operation,
   input  logic [7:0]              task_id,
   input  logic [7:0]              priority_req,
   input  logic                    res_ready,
   output prq_pkg::eng_status_type eng_status,
   output prq_pkg::eng_result_type eng_result
);

   localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CW = $clog2(MAX_TASKS + 1);

   // Slot memory, one write and one registered read per cycle
   prq_pkg::slot_type mem [MAX_TASKS];
   prq_pkg::slot_type rdata_ff;

   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   prq_pkg::slot_type mem_wdata;
   logic              mem_re;
   logic [AW-1:0]     mem_raddr;

   prq_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      k_ff, k_in;
   logic               found_ff, found_in;
   logic [1:0]         status_ff, status_in;
   logic [7:0]         id_ff, id_in;
   logic [7:0]         prio_ff, prio_in;
   logic [CW-1:0]      k_dec;

   assign k_dec = k_ff - 1'b1;

   // Memory access
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         prq_pkg::ST_IDLE: begin
            if (start) begin
               if (operation == prq_pkg::OP_REMOVE) begin
                  state_in = prq_pkg::ST_RM_RD;
               end else if (count_ff == CW'(MAX_TASKS)) begin
                  state_in = prq_pkg::ST_HEAD_RD;
               end else begin
                  state_in = prq_pkg::ST_INS_RD;
               end
            end
         end
         prq_pkg::ST_INS_RD: begin
            state_in = (k_ff == '0) ? prq_pkg::ST_HEAD_RD : prq_pkg::ST_INS_WR;
         end
         prq_pkg::ST_INS_WR: begin
            state_in = (rdata_ff.prio >= prio_ff) ? prq_pkg::ST_HEAD_RD
                                                  : prq_pkg::ST_INS_RD;
         end
         prq_pkg::ST_RM_RD: begin
            state_in = (k_ff == count_ff) ? prq_pkg::ST_HEAD_RD : prq_pkg::ST_RM_CHK;
         end
         prq_pkg::ST_RM_CHK:   state_in = prq_pkg::ST_RM_RD;
         prq_pkg::ST_HEAD_RD:  state_in = prq_pkg::ST_HEAD_WAIT;
         prq_pkg::ST_HEAD_WAIT: begin
            if (res_ready) begin
               state_in = prq_pkg::ST_IDLE;
            end
         end
         default: state_in = prq_pkg::ST_IDLE;
      endcase
   end

   // Datapath and memory controls
   always_comb begin
      count_in  = count_ff;
      k_in      = k_ff;
      found_in  = found_ff;
      status_in = status_ff;
      id_in     = id_ff;
      prio_in   = prio_ff;
      mem_we    = 1'b0;
      mem_waddr = k_ff[AW-1:0];
      mem_wdata = rdata_ff;
      mem_re    = 1'b0;
      mem_raddr = k_ff[AW-1:0];
      case (state_ff)
         prq_pkg::ST_IDLE: begin
            if (start) begin
               id_in     = task_id;
               prio_in   = priority_req;
               found_in  = 1'b0;
               status_in = prq_pkg::STATUS_OK;
               if (operation == prq_pkg::OP_REMOVE) begin
                  k_in = '0;
               end else begin
                  k_in = count_ff;
                  if (count_ff == CW'(MAX_TASKS)) begin
                     status_in = prq_pkg::STATUS_FULL;
                  end
               end
            end
         end
         // insert walks from the tail toward the head
         prq_pkg::ST_INS_RD: begin
            if (k_ff == '0) begin
               mem_we    = 1'b1;
               mem_wdata = '{prio: prio_ff, task_id: id_ff};
               count_in  = count_ff + 1'b1;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = k_dec[AW-1:0];
            end
         end
         prq_pkg::ST_INS_WR: begin
            mem_we = 1'b1;
            if (rdata_ff.prio >= prio_ff) begin
               mem_wdata = '{prio: prio_ff, task_id: id_ff};
               count_in  = count_ff + 1'b1;
            end else begin
               mem_wdata = rdata_ff;
               k_in      = k_dec;
            end
         end
         // remove walks from the head, closing the gap behind the match
         prq_pkg::ST_RM_RD: begin
            if (k_ff == count_ff) begin
               if (found_ff) begin
                  count_in = count_ff - 1'b1;
               end else begin
                  status_in = prq_pkg::STATUS_NOT_FOUND;
               end
            end else begin
               mem_re = 1'b1;
            end
         end
         prq_pkg::ST_RM_CHK: begin
            if (found_ff) begin
               mem_we    = 1'b1;
               mem_waddr = k_dec[AW-1:0];
            end else if (rdata_ff.task_id == id_ff) begin
               found_in = 1'b1;
            end
            k_in = k_ff + 1'b1;
         end
         prq_pkg::ST_HEAD_RD: begin
            mem_re    = 1'b1;
            mem_raddr = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= prq_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      k_ff      <= k_in;
      found_ff  <= found_in;
      status_ff <= status_in;
      id_ff     <= id_in;
      prio_ff   <= prio_in;
   end

   // Outputs
   always_comb begin
      eng_status.idle       = (state_ff == prq_pkg::ST_IDLE);
      eng_status.done       = (state_ff == prq_pkg::ST_HEAD_WAIT);
      eng_result.status     = status_ff;
      eng_result.head_valid = (count_ff != '0);
      eng_result.head_id    = (count_ff != '0) ? rdata_ff.task_id : 8'd0;
      eng_result.count      = 6'(count_ff);
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_TASKS))
      else $error("entry count above capacity");

   a_full_no_grow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == prq_pkg::ST_HEAD_RD && status_ff == prq_pkg::STATUS_FULL)
      |-> count_ff == CW'(MAX_TASKS))
      else $error("full status with room left");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == prq_pkg::ST_INS_WR && rdata_ff.prio >= prio_ff)
      |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not add an entry");
`endif

endmodule

@@ design/priority_ready_queue_core.sv @@
// One item is in work at a time. Insert walks from the tail toward the head past the entries
// that sort below the new task; a full-queue insert goes straight to the head read. Remove
// walks all queued entries. While the output register is occupied, a held-off rsp_tready
// stalls the finished item in the engine. Each walk step reads the slot memory, then writes
// it when an entry moves or lands. A finished word waits in the output register.
// Reset (synchronous, active high) empties the queue and clears the running task.
module priority_ready_queue_core #(
   parameter int MAX_TASKS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // task_id[7:0], priority_req[15:8]
   input  logic        req_tuser,   // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // status[1:0], switched[2], running_valid[3],
                                    // running_id[11:4], ready_count[17:12], zero pad
);

   prq_pkg::eng_status_type eng_status;
   prq_pkg::eng_result_type eng_result;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_data_ff, rsp_data_in;
   logic        cur_valid_ff, cur_valid_in;
   logic [7:0]  cur_task_ff, cur_task_in;
   logic        res_ready;
   logic        take;
   logic        switched;

   assign req_tready = eng_status.idle;
   assign res_ready  = !rsp_valid_ff || rsp_tready;
   assign take       = eng_status.done && res_ready;

   prq_engine #(
      .MAX_TASKS(MAX_TASKS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .start       (req_tvalid && req_tready),
      .operation   (req_tuser),
      .task_id     (req_tdata[7:0]),
      .priority_req(req_tdata[15:8]),
      .res_ready   (res_ready),
      .eng_status  (eng_status),
      .eng_result  (eng_result)
   );

   // Switch detection and result word
   always_comb begin
      switched = (eng_result.head_valid != cur_valid_ff) ||
                 (eng_result.head_id != cur_task_ff);
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      cur_valid_in = cur_valid_ff;
      cur_task_in  = cur_task_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'd0, eng_result.count, eng_result.head_id,
                         eng_result.head_valid, switched, eng_result.status};
         cur_valid_in = eng_result.head_valid;
         cur_task_in  = eng_result.head_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         cur_valid_ff <= 1'b0;
         cur_task_ff  <= 8'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cur_valid_ff <= cur_valid_in;
         cur_task_ff  <= cur_task_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTH
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("new word taken while one is in work");

   a_running_zero_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[3]) |-> rsp_tdata[11:4] == 8'd0)
      else $error("idle scheduler reports a running id");

   a_head_tracks: assert property (@(posedge clock) disable iff (reset)
      take |=> (cur_task_ff == rsp_tdata[11:4] && cur_valid_ff == rsp_tdata[3]))
      else $error("running task out of step with result word");
`endif

endmodule

@@ verif/tb_top.sv @@
module tb_top;

   localparam int QUEUE_DEPTH = 32;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 200;

   // One request word and one result word
   typedef struct packed {
      logic       op;
      logic [7:0] task_id;
      logic [7:0] prio;
   } request_type;

   typedef struct packed {
      logic [1:0] status;
      logic       switched;
      logic       running_valid;
      logic [7:0] running_id;
      logic [5:0] ready_count;
   } outcome_type;

   // Directed row: request plus an optional hand-typed outcome
   typedef struct {
      request_type request;
      logic        has_known;
      outcome_type known;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;

   priority_ready_queue_core #(.MAX_TASKS(QUEUE_DEPTH)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the ready queue
   logic [7:0]  shadow_id[QUEUE_DEPTH];
   logic [7:0]  shadow_prio[QUEUE_DEPTH];
   int          shadow_count = 0;
   logic [7:0]  shadow_running = '0;
   logic        shadow_running_valid = 1'b0;

   outcome_type pending_outcomes[$];
   int          mismatch_count = 0;
   int          idle_cycles = 0;
   int          sender_idle_pct = 0;
   int          receiver_idle_pct = 0;
   bit          receiver_hold = 1'b0;
   bit          timed_out = 1'b0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      mismatch_count++;
   endtask

   // Apply one request to the shadow queue and compute its outcome
   function automatic outcome_type schedule_step(input request_type r);
      outcome_type o;
      int pos;
      logic       new_valid;
      logic [7:0] new_id;
      pos = 0;
      o = '0;
      if (r.op == prq_pkg::OP_INSERT) begin
         if (shadow_count >= QUEUE_DEPTH) begin
            o.status = prq_pkg::STATUS_FULL;
         end else begin
            while (pos < shadow_count && shadow_prio[pos] >= r.prio) pos++;
            for (int k = shadow_count; k > pos; k--) begin
               shadow_id[k] = shadow_id[k-1];
               shadow_prio[k] = shadow_prio[k-1];
            end
            shadow_id[pos] = r.task_id;
            shadow_prio[pos] = r.prio;
            shadow_count++;
            o.status = prq_pkg::STATUS_OK;
         end
      end else begin
         while (pos < shadow_count && shadow_id[pos] != r.task_id) pos++;
         if (pos >= shadow_count) begin
            o.status = prq_pkg::STATUS_NOT_FOUND;
         end else begin
            for (int k = pos; k + 1 < shadow_count; k++) begin
               shadow_id[k] = shadow_id[k+1];
               shadow_prio[k] = shadow_prio[k+1];
            end
            shadow_count--;
            o.status = prq_pkg::STATUS_OK;
         end
      end
      new_valid = shadow_count > 0;
      new_id = new_valid ? shadow_id[0] : 8'd0;
      o.switched = (new_valid != shadow_running_valid) || (new_id != shadow_running);
      shadow_running_valid = new_valid;
      shadow_running = new_id;
      o.running_valid = new_valid;
      o.running_id = new_id;
      o.ready_count = 6'(shadow_count);
      return o;
   endfunction

   // Drop the offer; called at a clock edge where no new word follows
   task automatic release_request();
      req_tvalid <= 1'b0;
   endtask

   // Offer one word and wait for its acceptance; valid stays up until the
   // next offer or a release
   task automatic send_request(input request_type r, input bit has_known,
                               input outcome_type known);
      outcome_type predicted;
      while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         release_request();
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= r.op;
      req_tdata <= {r.prio, r.task_id};
      predicted = schedule_step(r);
      if (has_known && predicted != known)
         report_mismatch("directed row vs predictor", predicted, known);
      pending_outcomes.push_back(predicted);
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic request_type random_request(input int prio_span);
      request_type r;
      r.op = ($urandom_range(99) < 55) ? prq_pkg::OP_INSERT : prq_pkg::OP_REMOVE;
      r.prio = (prio_span >= 255) ? 8'($urandom) : 8'($urandom_range(prio_span));
      // removes mostly hit a queued id
      if (r.op == prq_pkg::OP_REMOVE && shadow_count > 0 && $urandom_range(9) < 8)
         r.task_id = shadow_id[$urandom_range(shadow_count - 1)];
      else if ($urandom_range(3) == 0)
         r.task_id = 8'($urandom);
      else
         r.task_id = 8'($urandom_range(15));
      return r;
   endfunction

   // Receiver readiness
   always @(posedge clock) begin
      if (reset || receiver_hold)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= !(receiver_idle_pct > 0 && $urandom_range(99) < receiver_idle_pct);
   end

   // Result checking
   always @(posedge clock) begin
      outcome_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status        = rsp_tdata[1:0];
         got.switched      = rsp_tdata[2];
         got.running_valid = rsp_tdata[3];
         got.running_id    = rsp_tdata[11:4];
         got.ready_count   = rsp_tdata[17:12];
         if (pending_outcomes.size() == 0) begin
            report_mismatch("unexpected result word", rsp_tdata, 0);
         end else begin
            want = pending_outcomes.pop_front();
            if (got.status != want.status)
               report_mismatch("status", got.status, want.status);
            if (got.switched != want.switched)
               report_mismatch("switched", got.switched, want.switched);
            if (got.running_valid != want.running_valid)
               report_mismatch("running_valid", got.running_valid, want.running_valid);
            if (got.running_id != want.running_id)
               report_mismatch("running_id", got.running_id, want.running_id);
            if (got.ready_count != want.ready_count)
               report_mismatch("ready_count", got.ready_count, want.ready_count);
         end
      end
   end

   // Watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // Long receiver hold-off, counted here while the sender keeps offering
   task automatic hold_receiver(input int cycles);
      receiver_hold = 1'b1;
      repeat (cycles) @(posedge clock);
      receiver_hold = 1'b0;
   endtask

   task automatic wait_all_results();
      release_request();
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   directed_row_type directed_rows[$];

   function automatic directed_row_type row(input logic op, input int id, input int prio,
                                            input logic has_known = 1'b0,
                                            input outcome_type known = '0);
      directed_row_type d;
      d.request = '{op, 8'(id), 8'(prio)};
      d.has_known = has_known;
      d.known = known;
      return d;
   endfunction

   initial begin
      request_type r;
      // remove on empty queue; inserts at both priority extremes; equal
      // priority order; duplicate ids; head with same id; back to empty
      directed_rows.push_back(row(prq_pkg::OP_REMOVE, 8'hff, 0, 1'b1,
                                  '{prq_pkg::STATUS_NOT_FOUND, 1'b0, 1'b0, 8'd0, 6'd0}));
      directed_rows.push_back(row(prq_pkg::OP_INSERT, 8'h00, 8'h00, 1'b1,
                                  '{prq_pkg::STATUS_OK, 1'b1, 1'b1, 8'h00, 6'd1}));
      directed_rows.push_back(row(prq_pkg::OP_INSERT, 8'hff, 8'hff, 1'b1,
                                  '{prq_pkg::STATUS_OK, 1'b1, 1'b1, 8'hff, 6'd2}));
      directed_rows.push_back(row(prq_pkg::OP_INSERT, 8'h55, 8'hff));
      directed_rows.push_back(row(prq_pkg::OP_INSERT, 8'haa, 8'h80));
      directed_rows.push_back(row(prq_pkg::OP_INSERT, 8'hff, 8'hff));
      directed_rows.push_back(row(prq_pkg::OP_REMOVE, 8'hff, 0));
      directed_rows.push_back(row(prq_pkg::OP_REMOVE, 8'h55, 0));
      directed_rows.push_back(row(prq_pkg::OP_REMOVE, 8'h12, 0, 1'b1,
                                  '{prq_pkg::STATUS_NOT_FOUND, 1'b0, 1'b1, 8'hff, 6'd3}));
      directed_rows.push_back(row(prq_pkg::OP_REMOVE, 8'hff, 8'hff));
      directed_rows.push_back(row(prq_pkg::OP_REMOVE, 8'haa, 0));
      directed_rows.push_back(row(prq_pkg::OP_REMOVE, 8'h00, 0, 1'b1,
                                  '{prq_pkg::STATUS_OK, 1'b1, 1'b0, 8'd0, 6'd0}));
      // fill to capacity, then one refused insert
      for (int k = 0; k < QUEUE_DEPTH; k++)
         directed_rows.push_back(row(prq_pkg::OP_INSERT, k, (k * 37) & 8'hff));
      directed_rows.push_back(row(prq_pkg::OP_INSERT, 8'h77, 8'h01, 1'b1,
                                  '{prq_pkg::STATUS_FULL, 1'b0, 1'b1, 8'd27, 6'd32}));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_request(directed_rows[i].request, directed_rows[i].has_known,
                      directed_rows[i].known);
      wait_all_results();

      // receiver stalls long while the sender keeps offering
      fork
         hold_receiver(400);
         begin
            repeat (40) send_request(random_request(255), 1'b0, '0);
            release_request();
         end
      join

      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 46 : 0;
         receiver_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 33 : 0;
         repeat (330) begin
            r = random_request(($urandom_range(3) == 0) ? 255 : 7);
            send_request(r, 1'b0, '0);
         end
         // sender pauses until everything is back
         wait_all_results();
      end

      wait_all_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_outcomes.size() == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end
endmodule

@@ sim.f @@
design/prq_pkg.sv
design/prq_engine.sv
design/priority_ready_queue_core.sv
verif/tb_top.sv
